[design/unique_number_table_fixer_core_assert.svh]
// Assertion macros used by the table fixer core RTL.
`ifndef UNIQUE_NUMBER_TABLE_FIXER_CORE_ASSERT_SVH
`define UNIQUE_NUMBER_TABLE_FIXER_CORE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define UNTF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("untf assertion failed");

// Checked on every clock edge, reset included.
`define UNTF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("untf assertion failed during reset");

`endif

[design/untf_pkg.sv]
package untf_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 24;

  // Request kinds carried in tuser
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PUSH  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_STORED     = 2'd0,
    STAT_RENUMBERED = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_CLEARED    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_SEARCH,
    ST_FINISH
  } state_e;

endpackage

[design/unique_number_table_fixer_core.sv]
// Channel  | Dir | tdata (low bit up)                      | tuser
// s_axis   | in  | number_in[15:0]                         | operation (0 clear, 1 push)
// m_axis   | out | number_out[15:0] slot[21:16] status[23:22] | -
//
// A clear, a push into a full table (rejected) or into an empty table goes straight
// to the finish step; other pushes walk the filled entries for duplicates, one read
// per cycle; renumbering a duplicate then tests one free-value candidate per cycle.
// rst_ni clears the entry count, the sequencer and the output valid, not the memory.
// A request is taken only in idle; the last step holds while the previous result
// still waits in the output register, so a long output stall delays the next one.
module unique_number_table_fixer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [untf_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,  // number_in[15:0]
  input  logic                              s_axis_tuser_i,  // operation
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [untf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o   // number_out, slot, status
);

  import untf_pkg::*;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0]  m_data_q, m_data_d;

  logic [CNT_W-1:0]        idx_q, idx_d;
  logic                    dup_q, dup_d;
  logic [TABLE_DEPTH-1:0]  taken_q, taken_d;
  logic [NUM_W-1:0]        req_q, req_d;
  logic [NUM_W-1:0]        res_num_q, res_num_d;
  status_e                 res_stat_q, res_stat_d;

  // Number memory, one read and one write port
  logic [NUM_W-1:0]        mem_q [TABLE_DEPTH];
  logic [NUM_W-1:0]        rd_data_q;
  logic                    rd_vld_q, rd_vld_d;
  logic                    rd_en, wr_en;

  logic                    accept;
  logic                    issue;
  logic                    small_val;

  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Walk still has entries to read
  assign issue     = (idx_q < count_q);
  assign small_val = (rd_data_q != '0) && (rd_data_q <= NUM_W'(TABLE_DEPTH));

  // Sequencer: next state and datapath control
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    idx_d      = idx_q;
    dup_d      = dup_q;
    taken_d    = taken_q;
    req_d      = req_q;
    res_num_d  = res_num_q;
    res_stat_d = res_stat_q;
    rd_en      = 1'b0;
    rd_vld_d   = 1'b0;
    wr_en      = 1'b0;

    // Drop the output once taken
    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = s_axis_tdata_i[NUM_W-1:0];
          idx_d   = '0;
          dup_d   = 1'b0;
          taken_d = '0;
          if (s_axis_tuser_i == OP_CLEAR) begin
            res_num_d  = '0;
            res_stat_d = STAT_CLEARED;
            state_d    = ST_FINISH;
          end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
            res_num_d  = '0;
            res_stat_d = STAT_FULL;
            state_d    = ST_FINISH;
          end else begin
            res_num_d  = s_axis_tdata_i[NUM_W-1:0];
            res_stat_d = STAT_STORED;
            state_d    = (count_q == '0) ? ST_FINISH : ST_WALK;
          end
        end
      end

      ST_WALK: begin
        // Issue one read per cycle, check the one returned
        if (issue) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
        end
        if (rd_vld_q) begin
          if (rd_data_q == req_q) begin
            dup_d = 1'b1;
          end
          if (small_val) begin
            taken_d[IDX_W'(rd_data_q - NUM_W'(1))] = 1'b1;
          end
        end
        if (!issue && !rd_vld_q) begin
          idx_d = '0;
          if (dup_q) begin
            res_stat_d = STAT_RENUMBERED;
            state_d    = ST_SEARCH;
          end else begin
            state_d    = ST_FINISH;
          end
        end
      end

      ST_SEARCH: begin
        // Test one candidate value per cycle, from 1 upward
        if (!taken_q[idx_q[IDX_W-1:0]]) begin
          res_num_d = NUM_W'(idx_q) + NUM_W'(1);
          state_d   = ST_FINISH;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end

      ST_FINISH: begin
        // Load the result once the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_stat_q, SLOT_W'(count_q), res_num_q};
          case (res_stat_q)
            STAT_CLEARED: count_d = '0;
            STAT_FULL:    count_d = count_q;
            default: begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          endcase
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      rd_vld_q  <= rd_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m_data_q   <= m_data_d;
    idx_q      <= idx_d;
    dup_q      <= dup_d;
    taken_q    <= taken_d;
    req_q      <= req_d;
    res_num_q  <= res_num_d;
    res_stat_q <= res_stat_d;
  end

  // Number memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IDX_W-1:0]] <= res_num_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[idx_q[IDX_W-1:0]];
    end
  end

`include "unique_number_table_fixer_core_assert.svh"

  `UNTF_ASSERT(a_count_range, count_q <= CNT_W'(TABLE_DEPTH))
  `UNTF_ASSERT(a_search_needs_dup, (state_q == ST_SEARCH) |-> (dup_q && count_q != '0))
  `UNTF_ASSERT(a_search_in_range, (state_q == ST_SEARCH) |-> (idx_q <= count_q))
  `UNTF_ASSERT(a_result_from_finish, $rose(m_valid_q) |-> $past(state_q == ST_FINISH))
  `UNTF_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_axis_tvalid_o)

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import untf_pkg::*;

  localparam int unsigned NUM_ITEMS   = 1700;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned MAX_CYCLES  = 1000000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic             op;
    logic [NUM_W-1:0] number;
  } svc_req_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } svc_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predicted table contents and fill level
  logic [NUM_W-1:0]  svc_table [TABLE_DEPTH];
  logic [SLOT_W-1:0] svc_count = '0;

  svc_req_t request_q [$];
  svc_res_t table_result_q [$];

  svc_req_t    drv_req;
  int unsigned drv_gap     = 0;
  int unsigned drv_items   = 0;
  bit          drv_idle_on = 1'b1;
  int unsigned accepted    = 0;
  int unsigned total_items = 0;

  int unsigned mon_stall   = 0;
  int unsigned mon_results = 0;
  bit          mon_idle_on = 1'b1;
  int unsigned fail_cnt    = 0;
  svc_res_t    mon_exp;

  int unsigned cycle_cnt = 0;

  unique_number_table_fixer_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit number_taken(logic [NUM_W-1:0] v);
    for (int k = 0; k < int'(svc_count); k++) begin
      if (svc_table[k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic svc_res_t table_update(svc_req_t req);
    svc_res_t    res;
    int unsigned cand;
    res.number = '0;
    res.slot   = svc_count;
    if (req.op == OP_CLEAR) begin
      svc_count  = '0;
      res.status = STAT_CLEARED;
    end else if (svc_count >= TABLE_DEPTH) begin
      res.status = STAT_FULL;
    end else begin
      if (number_taken(req.number)) begin
        // Search the smallest value from one upward not in the table
        cand = 1;
        while (cand <= 16'hFFFF && number_taken(cand[NUM_W-1:0])) cand++;
        res.number = (cand > 16'hFFFF) ? 16'hFFFF : cand[NUM_W-1:0];
        res.status = STAT_RENUMBERED;
      end else begin
        res.number = req.number;
        res.status = STAT_STORED;
      end
      svc_table[svc_count] = res.number;
      svc_count            = svc_count + 1'b1;
    end
    return res;
  endfunction

  task automatic queue_request(logic op, logic [NUM_W-1:0] number);
    svc_req_t req;
    req.op     = op;
    req.number = number;
    request_q.push_back(req);
    total_items++;
  endtask

  // Driver: present queued requests with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        table_result_q.push_back(table_update(drv_req));
        accepted++;
        drv_items++;
        if (drv_items % 64 == 0) drv_idle_on = ($urandom_range(0, 2) != 0);
        drv_gap = drv_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_q.size() > 0) begin
          drv_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drv_req.number;
          s_axis_tuser  <= drv_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the result side and check each result
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (table_result_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected result: number %h slot %0d status %0d",
                     m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tdata[23:22]);
        end else begin
          mon_exp = table_result_q.pop_front();
          if (m_axis_tdata[15:0] !== mon_exp.number ||
              m_axis_tdata[21:16] !== mon_exp.slot ||
              m_axis_tdata[23:22] !== mon_exp.status) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display("mismatch: exp number %h slot %0d status %0d, got %h %0d %0d",
                       mon_exp.number, mon_exp.slot, mon_exp.status,
                       m_axis_tdata[15:0], m_axis_tdata[21:16], m_axis_tdata[23:22]);
          end
        end
        mon_results++;
        if (mon_results % 50 == 0) mon_idle_on = ($urandom_range(0, 2) != 0);
        mon_stall = mon_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (mon_stall > 0) begin
        mon_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [NUM_W-1:0] v;
    logic [NUM_W-1:0] seq_vals [$];
    int unsigned      fill_len;

    // Directed: extremes, zero, renumbering and clears
    queue_request(OP_CLEAR, 16'h0000);
    queue_request(OP_PUSH,  16'h0000);
    queue_request(OP_PUSH,  16'h0000);
    queue_request(OP_PUSH,  16'h0001);
    queue_request(OP_PUSH,  16'hFFFF);
    queue_request(OP_PUSH,  16'hFFFF);
    queue_request(OP_PUSH,  16'hAAAA);
    queue_request(OP_PUSH,  16'h5555);
    queue_request(OP_PUSH,  16'h0003);
    queue_request(OP_PUSH,  16'h8000);
    queue_request(OP_PUSH,  16'h0001);
    queue_request(OP_CLEAR, 16'hFFFF);
    queue_request(OP_PUSH,  16'hFFFF);
    queue_request(OP_PUSH,  16'hFFFF);
    queue_request(OP_CLEAR, 16'h5555);
    queue_request(OP_CLEAR, 16'hAAAA);

    // Fill the table past full, then keep building random tables
    for (int k = 0; k < 34; k++) queue_request(OP_PUSH, NUM_W'($urandom_range(0, 20)));
    while (total_items < NUM_ITEMS) begin
      fill_len = ($urandom_range(0, 2) == 0) ? $urandom_range(32, 40) : $urandom_range(0, 31);
      queue_request(OP_CLEAR, NUM_W'($urandom));
      seq_vals.delete();
      for (int k = 0; k < int'(fill_len); k++) begin
        case ($urandom_range(0, 3))
          0: v = NUM_W'($urandom_range(0, 40));
          1: v = NUM_W'($urandom);
          2: v = (seq_vals.size() > 0) ? seq_vals[$urandom_range(0, seq_vals.size() - 1)]
                                       : 16'hFFFF;
          default: v = 16'hFFFF - NUM_W'($urandom_range(0, 63));
        endcase
        // Drop the table now and then in the middle of a build
        if ($urandom_range(0, 59) == 0) queue_request(OP_CLEAR, v);
        else queue_request(OP_PUSH, v);
        seq_vals.push_back(v);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(accepted == total_items && table_result_q.size() == 0)) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && table_result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/untf_pkg.sv
design/unique_number_table_fixer_core.sv
dv/tb.sv
